// ===== src/vtbb_pkg.sv =====
// vtbb_pkg: shared widths, types, register indexes and the rotation micro-op table
// used by every module of vertex_transform_bounding_box; no dependencies
`timescale 1ns / 1ps
package vtbb_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TRIG_BITS  = 18;
  localparam int TRIG_FRAC  = 16;
  localparam int CS_BITS    = 2 * TRIG_BITS;

  localparam int CW   = COORD_BITS;
  localparam int PW   = 2 * CW + 1;
  localparam int SH_W = $clog2(FRAC_BITS > TRIG_FRAC ? FRAC_BITS + 1 : TRIG_FRAC + 1);

  // configuration port
  localparam int CFG_DW   = 64;
  localparam int NUM_REGS = 7;
  localparam int CFG_IW   = $clog2(NUM_REGS);
  localparam int CFG_AW   = CFG_IW + 3;

  localparam logic [CFG_IW-1:0] REG_SCALE = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_PITCH = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_YAW   = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] REG_ROLL  = CFG_IW'(3);
  localparam logic [CFG_IW-1:0] REG_OFF_X = CFG_IW'(4);
  localparam logic [CFG_IW-1:0] REG_OFF_Y = CFG_IW'(5);
  localparam logic [CFG_IW-1:0] REG_OFF_Z = CFG_IW'(6);

  localparam logic [CW-1:0]      SCALE_RST = CW'(1) << FRAC_BITS;
  localparam logic [CS_BITS-1:0] TRIG_RST  = CS_BITS'(64'h1_0000_0000);

  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // axis codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // angle codes
  localparam logic [1:0] ANG_PITCH = 2'd0;
  localparam logic [1:0] ANG_YAW   = 2'd1;
  localparam logic [1:0] ANG_ROLL  = 2'd2;

  // second operand
  localparam logic [1:0] BS_SCALE = 2'd0;
  localparam logic [1:0] BS_COS   = 2'd1;
  localparam logic [1:0] BS_SIN   = 2'd2;

  // micro-op actions
  localparam logic [2:0] ACT_SET  = 3'd0;
  localparam logic [2:0] ACT_LOAD = 3'd1;
  localparam logic [2:0] ACT_TSUB = 3'd2;
  localparam logic [2:0] ACT_TADD = 3'd3;
  localparam logic [2:0] ACT_FSUB = 3'd4;
  localparam logic [2:0] ACT_FADD = 3'd5;

  localparam int NUM_OPS = 15;
  localparam int STEP_W  = $clog2(NUM_OPS);

  typedef struct packed {
    logic [CW-1:0]                scale;
    logic [2:0][CS_BITS-1:0]      trig;
    logic [2:0][CW-1:0]           offset;
  } cfg_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic          last;
  } vert_t;

  typedef struct packed {
    logic          kind;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [CW-1:0] diag;
    logic          last;
  } res_t;

  typedef struct packed {
    logic [1:0] asel;
    logic [1:0] bsel;
    logic [1:0] ang;
    logic [2:0] act;
    logic [1:0] dst;
    logic [1:0] dst_t;
  } op_t;

  function automatic op_t mk(input logic [1:0] asel, input logic [1:0] bsel,
                             input logic [1:0] ang, input logic [2:0] act,
                             input logic [1:0] dst, input logic [1:0] dst_t);
    op_t o;
    o.asel  = asel;
    o.bsel  = bsel;
    o.ang   = ang;
    o.act   = act;
    o.dst   = dst;
    o.dst_t = dst_t;
    return o;
  endfunction

  // scale, then pitch, yaw and roll, two products folded into each new coordinate
  function automatic op_t op_of(input logic [STEP_W-1:0] step);
    op_t o;
    unique case (step)
      STEP_W'(0):  o = mk(AX_X, BS_SCALE, ANG_PITCH, ACT_SET,  AX_X, AX_X);
      STEP_W'(1):  o = mk(AX_Y, BS_SCALE, ANG_PITCH, ACT_SET,  AX_Y, AX_Y);
      STEP_W'(2):  o = mk(AX_Z, BS_SCALE, ANG_PITCH, ACT_SET,  AX_Z, AX_Z);
      STEP_W'(3):  o = mk(AX_Y, BS_COS,   ANG_PITCH, ACT_LOAD, AX_Y, AX_Y);
      STEP_W'(4):  o = mk(AX_Z, BS_SIN,   ANG_PITCH, ACT_TSUB, AX_Y, AX_Y);
      STEP_W'(5):  o = mk(AX_Y, BS_SIN,   ANG_PITCH, ACT_LOAD, AX_Z, AX_Z);
      STEP_W'(6):  o = mk(AX_Z, BS_COS,   ANG_PITCH, ACT_FADD, AX_Z, AX_Y);
      STEP_W'(7):  o = mk(AX_X, BS_COS,   ANG_YAW,   ACT_LOAD, AX_X, AX_X);
      STEP_W'(8):  o = mk(AX_Z, BS_SIN,   ANG_YAW,   ACT_TADD, AX_X, AX_X);
      STEP_W'(9):  o = mk(AX_Z, BS_COS,   ANG_YAW,   ACT_LOAD, AX_Z, AX_Z);
      STEP_W'(10): o = mk(AX_X, BS_SIN,   ANG_YAW,   ACT_FSUB, AX_Z, AX_X);
      STEP_W'(11): o = mk(AX_X, BS_COS,   ANG_ROLL,  ACT_LOAD, AX_X, AX_X);
      STEP_W'(12): o = mk(AX_Y, BS_SIN,   ANG_ROLL,  ACT_TSUB, AX_X, AX_X);
      STEP_W'(13): o = mk(AX_X, BS_SIN,   ANG_ROLL,  ACT_LOAD, AX_Y, AX_Y);
      default:     o = mk(AX_Y, BS_COS,   ANG_ROLL,  ACT_FADD, AX_Y, AX_X);
    endcase
    return o;
  endfunction

  // clamp a one-bit-wider sum to the coordinate range
  function automatic logic [CW-1:0] sat_sum(input logic [CW:0] s);
    if (s[CW] != s[CW-1]) return s[CW] ? CMIN : CMAX;
    return s[CW-1:0];
  endfunction

endpackage

// ===== src/vtbb_front.sv =====
// vtbb_front: takes vertex transfers and runs scale, rotation and translation
// on one shared multiplier for scale and rotation, then translation; depends on vtbb_pkg
`timescale 1ns / 1ps
module vtbb_front
  import vtbb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_stall,
  input  vert_t in_vert,
  output logic  push_valid,
  output vert_t push_data,
  input  logic  push_full
);

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_RUN   = 2'd1;
  localparam logic [1:0] F_XLATE = 2'd2;
  localparam logic [1:0] F_PUSH  = 2'd3;

  logic [1:0]              st_r, st_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    phase_r, phase_nxt;
  logic [CW-1:0]           crd_r [3];
  logic [CW-1:0]           crd_nxt [3];
  logic [CW-1:0]           acc_r, acc_nxt;
  logic [CW-1:0]           t_r, t_nxt;
  logic                    last_r, last_nxt;
  logic signed [PW-1:0]    p_r, p_nxt;

  op_t                     op;
  logic signed [CW-1:0]    a_op;
  logic signed [CW:0]      b_op;
  logic [TRIG_BITS-1:0]    trig_f;
  logic [SH_W-1:0]         shamt;
  logic signed [PW-1:0]    sh;
  logic [CW-1:0]           ps;
  logic [CW-1:0]           r_add, r_sub;

  assign in_stall   = (st_r != F_IDLE);
  assign push_valid = (st_r == F_PUSH);
  assign push_data  = '{x: crd_r[0], y: crd_r[1], z: crd_r[2], last: last_r};

  always_comb begin
    op     = op_of(step_r);
    a_op   = $signed(crd_r[op.asel]);
    trig_f = (op.bsel == BS_COS) ? cfg.trig[op.ang][CS_BITS-1:TRIG_BITS]
                                 : cfg.trig[op.ang][TRIG_BITS-1:0];
    if (op.bsel == BS_SCALE) begin
      b_op  = $signed({1'b0, cfg.scale});
      shamt = SH_W'(FRAC_BITS);
    end else begin
      b_op  = (CW+1)'($signed(trig_f));
      shamt = SH_W'(TRIG_FRAC);
    end
    p_nxt = a_op * b_op;
    // floor shift of the registered product, then clamp
    sh = p_r >>> shamt;
    if ((&sh[PW-1:CW-1]) || !(|sh[PW-1:CW-1])) ps = sh[CW-1:0];
    else                                         ps = sh[PW-1] ? CMIN : CMAX;
    r_add = sat_sum({acc_r[CW-1], acc_r} + {ps[CW-1], ps});
    r_sub = sat_sum({acc_r[CW-1], acc_r} - {ps[CW-1], ps});
  end

  always_comb begin
    st_nxt    = st_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    crd_nxt   = crd_r;
    acc_nxt   = acc_r;
    t_nxt     = t_r;
    last_nxt  = last_r;
    unique case (st_r)
      F_IDLE: begin
        if (in_valid) begin
          crd_nxt[0] = in_vert.x;
          crd_nxt[1] = in_vert.y;
          crd_nxt[2] = in_vert.z;
          last_nxt   = in_vert.last;
          step_nxt   = '0;
          phase_nxt  = 1'b0;
          st_nxt     = F_RUN;
        end
      end
      F_RUN: begin
        phase_nxt = ~phase_r;
        if (phase_r) begin
          unique case (op.act)
            ACT_SET:  crd_nxt[op.dst] = ps;
            ACT_LOAD: acc_nxt = ps;
            ACT_TSUB: t_nxt = r_sub;
            ACT_TADD: t_nxt = r_add;
            ACT_FSUB: begin
              crd_nxt[op.dst]   = r_sub;
              crd_nxt[op.dst_t] = t_r;
            end
            ACT_FADD: begin
              crd_nxt[op.dst]   = r_add;
              crd_nxt[op.dst_t] = t_r;
            end
            default: ;
          endcase
          if (step_r == STEP_W'(NUM_OPS - 1)) st_nxt = F_XLATE;
          else                                 step_nxt = step_r + 1'b1;
        end
      end
      F_XLATE: begin
        for (int k = 0; k < 3; k++) begin
          crd_nxt[k] = sat_sum({crd_r[k][CW-1], crd_r[k]} +
                               {cfg.offset[k][CW-1], cfg.offset[k]});
        end
        st_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!push_full) st_nxt = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= F_IDLE;
      phase_r <= 1'b0;
      step_r  <= '0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
    end
    crd_r  <= crd_nxt;
    acc_r  <= acc_nxt;
    t_r    <= t_nxt;
    last_r <= last_nxt;
    p_r    <= p_nxt;
  end

endmodule

// ===== src/vtbb_queue.sv =====
// vtbb_queue: two-entry queue of transformed vertices between front and back
// depends on vtbb_pkg
`timescale 1ns / 1ps
module vtbb_queue
  import vtbb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  vert_t push_data,
  output logic  full,
  input  logic  pop,
  output vert_t pop_data,
  output logic  empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  vert_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == (PTR_W+1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

// ===== src/vtbb_back.sv =====
// vtbb_back: result register, running box, centre and bit-serial diagonal root
// depends on vtbb_pkg
`timescale 1ns / 1ps
module vtbb_back
  import vtbb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_empty,
  input  vert_t q_data,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_res
);

  localparam int RW    = 2 * CW + 2;
  localparam int REM_W = CW + 4;
  localparam int CNT_W = $clog2(CW + 2);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_VERT = 3'd1;
  localparam logic [2:0] B_SQ   = 3'd2;
  localparam logic [2:0] B_ROOT = 3'd3;
  localparam logic [2:0] B_FIN  = 3'd4;
  localparam logic [2:0] B_SUM  = 3'd5;

  logic [2:0]       st_r;
  logic             first_r, last_r;
  logic [CW-1:0]    mx_r [3];
  logic [CW-1:0]    mn_r [3];
  logic [CW-1:0]    d_r [3];
  logic [CW-1:0]    v [3];
  logic [CW:0]      dsum [3];
  logic [CW:0]      csum [3];
  logic [2*CW-1:0]  prod_r;
  logic [RW-1:0]    acc_r, rad_r;
  logic [REM_W-1:0] rem_r, rem_sh, trial;
  logic [CW:0]      root_r;
  logic [CNT_W-1:0] cnt_r;
  res_t             res_r;

  assign out_valid = (st_r == B_VERT) || (st_r == B_SUM);
  assign out_res   = res_r;
  assign q_pop     = (st_r == B_IDLE) && !q_empty;

  always_comb begin
    v[0] = q_data.x;
    v[1] = q_data.y;
    v[2] = q_data.z;
    for (int k = 0; k < 3; k++) begin
      dsum[k] = {mx_r[k][CW-1], mx_r[k]} - {mn_r[k][CW-1], mn_r[k]};
      csum[k] = {mx_r[k][CW-1], mx_r[k]} + {mn_r[k][CW-1], mn_r[k]};
    end
    rem_sh = {rem_r[REM_W-3:0], rad_r[RW-1:RW-2]};
    trial  = {1'b0, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= B_IDLE;
      first_r <= 1'b1;
      for (int k = 0; k < 3; k++) begin
        mx_r[k] <= '0;
        mn_r[k] <= '0;
      end
    end else begin
      unique case (st_r)
        B_IDLE: begin
          if (!q_empty) begin
            for (int k = 0; k < 3; k++) begin
              if (first_r || $signed(v[k]) > $signed(mx_r[k])) mx_r[k] <= v[k];
              if (first_r || $signed(v[k]) < $signed(mn_r[k])) mn_r[k] <= v[k];
            end
            first_r <= 1'b0;
            last_r  <= q_data.last;
            res_r   <= '{kind: 1'b0, x: q_data.x, y: q_data.y, z: q_data.z,
                         diag: '0, last: 1'b0};
            st_r    <= B_VERT;
          end
        end
        B_VERT: begin
          if (!out_stall) begin
            if (last_r) begin
              for (int k = 0; k < 3; k++) d_r[k] <= dsum[k][CW-1:0];
              acc_r <= '0;
              cnt_r <= '0;
              st_r  <= B_SQ;
            end else begin
              st_r <= B_IDLE;
            end
          end
        end
        B_SQ: begin
          // squares go through a product register and are accumulated from it
          if (cnt_r != CNT_W'(3)) prod_r <= d_r[cnt_r[1:0]] * d_r[cnt_r[1:0]];
          if (cnt_r != '0) acc_r <= acc_r + RW'(prod_r);
          if (cnt_r == CNT_W'(3)) begin
            rad_r  <= acc_r + RW'(prod_r);
            rem_r  <= '0;
            root_r <= '0;
            cnt_r  <= '0;
            st_r   <= B_ROOT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        B_ROOT: begin
          // one root bit per cycle, restoring form
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[CW-1:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[CW-1:0], 1'b0};
          end
          rad_r <= rad_r << 2;
          if (cnt_r == CNT_W'(CW)) st_r <= B_FIN;
          else                     cnt_r <= cnt_r + 1'b1;
        end
        B_FIN: begin
          res_r <= '{kind: 1'b1, x: csum[0][CW:1], y: csum[1][CW:1], z: csum[2][CW:1],
                     diag: root_r[CW] ? {CW{1'b1}} : root_r[CW-1:0], last: 1'b1};
          st_r  <= B_SUM;
        end
        B_SUM: begin
          if (!out_stall) begin
            for (int k = 0; k < 3; k++) begin
              mx_r[k] <= '0;
              mn_r[k] <= '0;
            end
            first_r <= 1'b1;
            st_r    <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== src/vertex_transform_bounding_box.sv =====
// vertex_transform_bounding_box: top level with config registers, front, queue, back
// depends on vtbb_pkg, vtbb_front, vtbb_queue, vtbb_back
//
//  channel | handshake            | payload
//  in_     | in_valid / in_stall  | vert_x, vert_y, vert_z, last_vertex
//  out_    | out_valid / out_stall| kind, out_x/y/z, diagonal, last_result
//  config  | psel/penable/pwrite  | paddr (8-byte slots), pwdata, prdata
//
// the front takes one vertex at a time: 15 products on one shared multiplier,
// then translate, then push, held while the queue is full, then idle for the next
// the back shows a vertex the cycle after it leaves the queue; on the last vertex
// the summary follows that transfer after the squares, the root and the result fill
// reset is synchronous, rst_n low; it restores register defaults and an empty box
// a stalled output holds its transfer; the two-entry queue lets the front go on
`timescale 1ns / 1ps
module vertex_transform_bounding_box
  import vtbb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CW-1:0]        in_vert_x,
  input  logic [CW-1:0]        in_vert_y,
  input  logic [CW-1:0]        in_vert_z,
  input  logic                 in_last_vertex,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [CW-1:0]        out_out_x,
  output logic [CW-1:0]        out_out_y,
  output logic [CW-1:0]        out_out_z,
  output logic [CW-1:0]        out_diagonal,
  output logic                 out_last_result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [CFG_DW-1:0]    pwdata,
  output logic [CFG_DW-1:0]    prdata,
  output logic                 pready
);

  cfg_t              cfg_r;
  logic [CFG_IW-1:0] reg_idx;
  logic              wr_en;
  vert_t             in_vert, push_data, pop_data;
  logic              push_valid, push_full, q_pop, q_empty;
  res_t              res;

  // register slots are 8 bytes apart
  assign reg_idx = paddr[CFG_AW-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale  <= SCALE_RST;
      cfg_r.trig   <= {3{TRIG_RST}};
      cfg_r.offset <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SCALE: cfg_r.scale     <= pwdata[CW-1:0];
        REG_PITCH: cfg_r.trig[0]   <= pwdata[CS_BITS-1:0];
        REG_YAW:   cfg_r.trig[1]   <= pwdata[CS_BITS-1:0];
        REG_ROLL:  cfg_r.trig[2]   <= pwdata[CS_BITS-1:0];
        REG_OFF_X: cfg_r.offset[0] <= pwdata[CW-1:0];
        REG_OFF_Y: cfg_r.offset[1] <= pwdata[CW-1:0];
        REG_OFF_Z: cfg_r.offset[2] <= pwdata[CW-1:0];
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCALE: prdata = CFG_DW'(cfg_r.scale);
      REG_PITCH: prdata = CFG_DW'(cfg_r.trig[0]);
      REG_YAW:   prdata = CFG_DW'(cfg_r.trig[1]);
      REG_ROLL:  prdata = CFG_DW'(cfg_r.trig[2]);
      REG_OFF_X: prdata = CFG_DW'(cfg_r.offset[0]);
      REG_OFF_Y: prdata = CFG_DW'(cfg_r.offset[1]);
      REG_OFF_Z: prdata = CFG_DW'(cfg_r.offset[2]);
      default:   prdata = '0;
    endcase
  end

  assign in_vert = '{x: in_vert_x, y: in_vert_y, z: in_vert_z, last: in_last_vertex};

  // front: transform one vertex at a time
  vtbb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_vert    (in_vert),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_full  (push_full)
  );

  // queue decouples the transform from output stalls
  vtbb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .full      (push_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // back: box tracking and result transfers
  vtbb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_kind        = res.kind;
  assign out_out_x       = res.x;
  assign out_out_y       = res.y;
  assign out_out_z       = res.z;
  assign out_diagonal    = res.diag;
  assign out_last_result = res.last;

endmodule

// ===== src/vtbb_checker.sv =====
// vtbb_props: port-level checks on vertex_transform_bounding_box, bound to the top
// depends on vtbb_pkg
`timescale 1ns / 1ps
module vtbb_props
  import vtbb_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_kind,
  input logic [CW-1:0]        out_out_x,
  input logic [CW-1:0]        out_out_y,
  input logic [CW-1:0]        out_out_z,
  input logic [CW-1:0]        out_diagonal,
  input logic                 out_last_result
);

  // a held result keeps its kind, coordinates and diagonal
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_kind) && $stable(out_out_x)
      && $stable(out_out_y) && $stable(out_out_z) && $stable(out_diagonal)))
    else $error("result changed while stalled");

  // vertex results carry no diagonal and never close the run
  a_vert_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_kind) |-> (out_diagonal == '0 && !out_last_result))
    else $error("vertex result with summary fields set");

  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind) |-> out_last_result)
    else $error("summary without last flag");

  // the front is busy after taking a vertex
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second vertex taken in back-to-back cycles");

  // a summary is never followed directly by another summary
  a_no_double_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_kind) |=> !(out_valid && out_kind))
    else $error("two summaries in a row");

endmodule

bind vertex_transform_bounding_box vtbb_props u_vtbb_props (.*);

// ===== verif/vtbb_checker.sv =====
// vtbb_checker: watches the vertex, result and register ports of the block,
// predicts every result and compares it; depends on vtbb_pkg only
`timescale 1ns / 1ps
module vtbb_checker
  import vtbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [CW-1:0]     in_vert_x,
  input  logic [CW-1:0]     in_vert_y,
  input  logic [CW-1:0]     in_vert_z,
  input  logic              in_last_vertex,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_kind,
  input  logic [CW-1:0]     out_out_x,
  input  logic [CW-1:0]     out_out_y,
  input  logic [CW-1:0]     out_out_z,
  input  logic [CW-1:0]     out_diagonal,
  input  logic              out_last_result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                fails,
  output int                pending
);

  localparam longint C_HI = 64'sd2147483647;
  localparam longint C_LO = -64'sd2147483648;

  logic [CW-1:0]      scale;
  logic [CS_BITS-1:0] trig [3];
  longint             offs [3];
  longint             box_max [3];
  longint             box_min [3];
  bit                 box_fresh;
  res_t               expected_q [$];

  assign pending = expected_q.size();

  function automatic longint clamp(input logic signed [127:0] v);
    if (v > C_HI) return C_HI;
    if (v < C_LO) return C_LO;
    return longint'(v);
  endfunction

  // floor of a*b / 2^frac, clamped
  function automatic longint fx_mul(input longint a, input longint b, input int frac);
    logic signed [127:0] p;
    p = a;
    p = p * b;
    return clamp(p >>> frac);
  endfunction

  function automatic longint cos_of(input int k);
    return longint'(signed'(trig[k][2*TRIG_BITS-1:TRIG_BITS]));
  endfunction

  function automatic longint sin_of(input int k);
    return longint'(signed'(trig[k][TRIG_BITS-1:0]));
  endfunction

  function automatic logic [CW-1:0] root_sat(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 50; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    if (r > 128'hFFFF_FFFF) return '1;
    return r[CW-1:0];
  endfunction

  task automatic predict_vertex(input logic [CW-1:0] vx, input logic [CW-1:0] vy,
                                input logic [CW-1:0] vz, input logic last);
    longint x, y, z, t, s, c, sn;
    longint v [3];
    logic [127:0] sq;
    longint d;
    res_t r;
    s = longint'(scale);
    x = fx_mul(longint'(signed'(vx)), s, FRAC_BITS);
    y = fx_mul(longint'(signed'(vy)), s, FRAC_BITS);
    z = fx_mul(longint'(signed'(vz)), s, FRAC_BITS);
    // pitch about x
    c = cos_of(ANG_PITCH); sn = sin_of(ANG_PITCH);
    t = clamp(fx_mul(y, c, TRIG_FRAC) - fx_mul(z, sn, TRIG_FRAC));
    z = clamp(fx_mul(y, sn, TRIG_FRAC) + fx_mul(z, c, TRIG_FRAC));
    y = t;
    // yaw about y
    c = cos_of(ANG_YAW); sn = sin_of(ANG_YAW);
    t = clamp(fx_mul(x, c, TRIG_FRAC) + fx_mul(z, sn, TRIG_FRAC));
    z = clamp(fx_mul(z, c, TRIG_FRAC) - fx_mul(x, sn, TRIG_FRAC));
    x = t;
    // roll about z
    c = cos_of(ANG_ROLL); sn = sin_of(ANG_ROLL);
    t = clamp(fx_mul(x, c, TRIG_FRAC) - fx_mul(y, sn, TRIG_FRAC));
    y = clamp(fx_mul(x, sn, TRIG_FRAC) + fx_mul(y, c, TRIG_FRAC));
    x = t;
    v[0] = clamp(x + offs[0]);
    v[1] = clamp(y + offs[1]);
    v[2] = clamp(z + offs[2]);
    for (int a = 0; a < 3; a++) begin
      if (box_fresh || v[a] > box_max[a]) box_max[a] = v[a];
      if (box_fresh || v[a] < box_min[a]) box_min[a] = v[a];
    end
    box_fresh = 0;
    r = '0;
    r.x = v[0][CW-1:0];
    r.y = v[1][CW-1:0];
    r.z = v[2][CW-1:0];
    expected_q = {expected_q, r};
    if (last) begin
      sq = '0;
      for (int a = 0; a < 3; a++) begin
        d = box_max[a] - box_min[a];
        sq = sq + 128'(d) * 128'(d);
      end
      r.kind = 1'b1;
      r.x = CW'((box_max[0] + box_min[0]) >>> 1);
      r.y = CW'((box_max[1] + box_min[1]) >>> 1);
      r.z = CW'((box_max[2] + box_min[2]) >>> 1);
      r.diag = root_sat(sq);
      r.last = 1'b1;
      expected_q = {expected_q, r};
      for (int a = 0; a < 3; a++) begin
        box_max[a] = 0;
        box_min[a] = 0;
      end
      box_fresh = 1;
    end
  endtask

  task automatic check_field(input string name, input logic [CW-1:0] exp_v,
                             input logic [CW-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    logic [CFG_IW-1:0] idx;
    if (!rst_n) begin
      scale = SCALE_RST;
      for (int k = 0; k < 3; k++) begin
        trig[k] = TRIG_RST;
        offs[k] = 0;
        box_max[k] = 0;
        box_min[k] = 0;
      end
      box_fresh = 1;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = paddr[CFG_AW-1:3];
        case (idx)
          REG_SCALE: scale = pwdata[CW-1:0];
          REG_PITCH: trig[ANG_PITCH] = pwdata[CS_BITS-1:0];
          REG_YAW:   trig[ANG_YAW] = pwdata[CS_BITS-1:0];
          REG_ROLL:  trig[ANG_ROLL] = pwdata[CS_BITS-1:0];
          REG_OFF_X: offs[0] = longint'(signed'(pwdata[CW-1:0]));
          REG_OFF_Y: offs[1] = longint'(signed'(pwdata[CW-1:0]));
          REG_OFF_Z: offs[2] = longint'(signed'(pwdata[CW-1:0]));
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_vertex(in_vert_x, in_vert_y, in_vert_z, in_last_vertex);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer, kind %0d x %h", out_kind, out_out_x);
          fails++;
        end else begin
          e = expected_q.pop_front();
          check_field("kind", CW'(e.kind), CW'(out_kind));
          check_field("out_x", e.x, out_out_x);
          check_field("out_y", e.y, out_out_y);
          check_field("out_z", e.z, out_out_z);
          check_field("diagonal", e.diag, out_diagonal);
          check_field("last_result", CW'(e.last), CW'(out_last_result));
        end
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
// tb: stimulus and verdict for vertex_transform_bounding_box
// depends on vtbb_pkg, the block and vtbb_checker
`timescale 1ns / 1ps
module tb;
  import vtbb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CW-1:0]     in_vert_x;
  logic [CW-1:0]     in_vert_y;
  logic [CW-1:0]     in_vert_z;
  logic              in_last_vertex;
  logic              out_valid;
  logic              out_stall;
  logic              out_kind;
  logic [CW-1:0]     out_out_x;
  logic [CW-1:0]     out_out_y;
  logic [CW-1:0]     out_out_z;
  logic [CW-1:0]     out_diagonal;
  logic              out_last_result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int fails;
  int pending;
  int cycles;
  bit calm;       // no idling on either side
  bit hold_req;   // ask the receiver for one long hold-off
  bit hold_done;  // receiver has served the hold-off

  vertex_transform_bounding_box dut (.*);

  vtbb_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_vert_x, .in_vert_y, .in_vert_z,
    .in_last_vertex, .out_valid, .out_stall, .out_kind, .out_out_x, .out_out_y,
    .out_out_z, .out_diagonal, .out_last_result, .psel, .penable, .pwrite,
    .pready, .paddr, .pwdata, .fails, .pending
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, free stretches, and one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_done = 1;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_all(input logic [CW-1:0] sc, input logic [CS_BITS-1:0] p,
                           input logic [CS_BITS-1:0] y, input logic [CS_BITS-1:0] r,
                           input logic [CW-1:0] ox, input logic [CW-1:0] oy,
                           input logic [CW-1:0] oz);
    write_reg(REG_SCALE, CFG_DW'(sc));
    write_reg(REG_PITCH, CFG_DW'(p));
    write_reg(REG_YAW, CFG_DW'(y));
    write_reg(REG_ROLL, CFG_DW'(r));
    write_reg(REG_OFF_X, CFG_DW'(ox));
    write_reg(REG_OFF_Y, CFG_DW'(oy));
    write_reg(REG_OFF_Z, CFG_DW'(oz));
  endtask

  // one vertex transfer, with an optional gap in front
  task automatic send_vertex(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [CW-1:0] z, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_vert_x      <= x;
    in_vert_y      <= y;
    in_vert_z      <= z;
    in_last_vertex <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // wait for every expected result, summaries included, then idle before the next phase
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (80) @(posedge clk);
  endtask

  // mostly modest coordinates, sometimes anything
  function automatic logic [CW-1:0] rand_coord();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
  endfunction

  // cos/sin pair: mostly within +-1.0, sometimes any 18-bit codes
  function automatic logic [CS_BITS-1:0] rand_trig();
    logic [TRIG_BITS-1:0] c, s;
    if ($urandom_range(0, 3) == 0) begin
      c = TRIG_BITS'($urandom);
      s = TRIG_BITS'($urandom);
    end else begin
      c = TRIG_BITS'($urandom_range(0, 32'h20000) - 32'h10000);
      s = TRIG_BITS'($urandom_range(0, 32'h20000) - 32'h10000);
    end
    return {c, s};
  endfunction

  task automatic send_meshes(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 10);
      // each mesh ends on its marked vertex
      for (int i = 0; i < len; i++)
        send_vertex(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    logic [CW-1:0] sc;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_vert_x      <= '0;
    in_vert_y      <= '0;
    in_vert_z      <= '0;
    in_last_vertex <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    calm = 0;
    hold_req = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: single-vertex mesh, extremes, mixed signs
    send_vertex(32'h0, 32'h0, 32'h0, 1'b1);
    send_vertex(CMAX, CMAX, CMAX, 1'b0);
    send_vertex(CMIN, CMIN, CMIN, 1'b0);
    send_vertex(32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
    drain();

    // largest scale, cos at its top, sin at its bottom, offsets at the top
    write_all(32'hFFFF_FFFF, {18'h1FFFF, 18'h20000}, {18'h1FFFF, 18'h20000},
              {18'h1FFFF, 18'h20000}, CMAX, CMAX, CMAX);
    send_vertex(CMAX, CMIN, 32'h1, 1'b0);
    send_vertex(CMIN, CMAX, 32'hFFFF_FFFF, 1'b0);
    send_vertex(32'h0, 32'h0, 32'h0, 1'b1);
    drain();

    // zero scale, cos at its bottom, sin at its top, offsets at the bottom
    write_all(32'h0, {18'h20000, 18'h1FFFF}, {18'h20000, 18'h1FFFF},
              {18'h20000, 18'h1FFFF}, CMIN, CMIN, CMIN);
    send_vertex(CMAX, CMAX, CMAX, 1'b0);
    send_vertex(CMIN, CMIN, CMIN, 1'b1);
    drain();

    // identity rotation with a box spanning the whole range
    write_all(32'h0001_0000, {18'h10000, 18'h0}, {18'h10000, 18'h0},
              {18'h10000, 18'h0}, 32'h0, 32'h0, 32'h0);
    send_vertex(CMAX, CMAX, CMAX, 1'b0);
    send_vertex(CMIN, CMIN, CMIN, 1'b1);
    send_vertex(32'h0001_8000, 32'hFFFE_8000, 32'h7, 1'b0);
    send_vertex(32'hFFFF_FFFF, 32'h1, 32'h8000_0001, 1'b1);
    drain();

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < 5; ph++) begin
      if ($urandom_range(0, 3) == 0) sc = $urandom;
      else sc = $urandom_range(32'h4000, 32'h40000);
      write_all(sc, rand_trig(), rand_trig(), rand_trig(),
                rand_coord(), rand_coord(), rand_coord());
      // long receiver hold-off so the block backs up onto its input
      if (ph == 1) hold_req = 1;
      // final phase runs with no idling
      if (ph == 4) calm = 1;
      send_meshes(95);
      drain();
    end

    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
